### rtl/jhmd_pkg.sv
// shared types and constants of the huffman mcu decoder
`default_nettype none
package jhmd_pkg;

    localparam int MAX_COMPONENTS    = 4;
    localparam int TABLES_PER_CLASS  = 4;
    localparam int MAX_CODE_LENGTH   = 16;
    localparam int SYMBOLS_PER_TABLE = 256;

    // input actions
    localparam logic [1:0] ACT_SCAN   = 2'd0;
    localparam logic [1:0] ACT_COUNT  = 2'd1;
    localparam logic [1:0] ACT_SYMBOL = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_COEF    = 3'd0;
    localparam logic [2:0] KIND_EOB     = 3'd1;
    localparam logic [2:0] KIND_RESTART = 3'd2;
    localparam logic [2:0] KIND_STOP    = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd4;

    // decode phases
    localparam logic [1:0] PH_DC_CODE = 2'd0;
    localparam logic [1:0] PH_DC_BITS = 2'd1;
    localparam logic [1:0] PH_AC_CODE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COMPONENT_COUNT = 2'd0;
    localparam logic [1:0] CFG_SAMPLING        = 2'd1;
    localparam logic [1:0] CFG_TABLE_SELECT    = 2'd2;

    // marker bytes
    localparam logic [7:0] BYTE_FF       = 8'hFF;
    localparam logic [7:0] RST_MASK      = 8'hF8;
    localparam logic [7:0] RST_CODE      = 8'hD0;
    localparam logic [6:0] LAST_POSITION = 7'd63;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  comp;
        logic [3:0]  blk;
        logic [5:0]  pos;
        logic [15:0] coef;
        logic        done;
    } t_result;

    typedef struct packed {
        logic take;
        logic wr_count;
        logic wr_sym;
        logic set_ff;
        logic clr_ff;
        logic restart;
        logic stop;
        logic load_bits;
        logic stuffed;
        logic bit_step;
        logic cmp_step;
        logic sym_step;
        logic fin_step;
        logic eob_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       saw_ff;
        logic       byte_ff;
        logic       byte_rst;
        logic       byte_zero;
        logic       code_phase;
        logic       val_done;
        logic       match;
        logic       sym_zero;
        logic       fin_eob;
        logic       bits_done;
        logic       can_emit;
        logic       flush_ok;
        logic       pend_valid;
    } t_status;

endpackage
`default_nettype wire

### rtl/jhmd_ctrl.sv
// sequencer of the huffman mcu decoder
`default_nettype none
module jhmd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_take,
    input  jhmd_pkg::t_status i_st,
    output logic              o_ready,
    output jhmd_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_BIT, S_CMP, S_SYM, S_FIN, S_EOB, S_NEXT, S_FLUSH
    } t_state;

    t_state r_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.take = i_take;
            S_DISPATCH: begin
                priority if (i_st.action == jhmd_pkg::ACT_COUNT) begin
                    o_cmd.wr_count = 1'b1;
                end else if (i_st.action == jhmd_pkg::ACT_SYMBOL) begin
                    o_cmd.wr_sym = 1'b1;
                end else if (i_st.action == jhmd_pkg::ACT_SCAN) begin
                    if (i_st.saw_ff) begin
                        priority if (i_st.byte_ff) begin
                        end else if (i_st.byte_rst) begin
                            o_cmd.restart = i_st.can_emit;
                            o_cmd.clr_ff  = i_st.can_emit;
                        end else if (!i_st.byte_zero) begin
                            o_cmd.stop   = i_st.can_emit;
                            o_cmd.clr_ff = i_st.can_emit;
                        end else begin
                            o_cmd.clr_ff    = 1'b1;
                            o_cmd.load_bits = 1'b1;
                            o_cmd.stuffed   = 1'b1;
                        end
                    end else if (i_st.byte_ff) begin
                        o_cmd.set_ff = 1'b1;
                    end else begin
                        o_cmd.load_bits = 1'b1;
                    end
                end else begin
                end
            end
            S_BIT:   o_cmd.bit_step = 1'b1;
            S_CMP:   o_cmd.cmp_step = i_st.can_emit;
            S_SYM:   o_cmd.sym_step = 1'b1;
            S_FIN:   o_cmd.fin_step = i_st.can_emit;
            S_EOB:   o_cmd.eob_step = i_st.can_emit;
            S_NEXT: begin
            end
            S_FLUSH: o_cmd.flush = i_st.flush_ok;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_take) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    if (o_cmd.load_bits) r_state <= S_BIT;
                    else if (o_cmd.restart || o_cmd.stop) r_state <= S_FLUSH;
                    else if (!(i_st.action == jhmd_pkg::ACT_SCAN && i_st.saw_ff
                               && !i_st.byte_ff && !i_st.byte_zero)) r_state <= S_IDLE;
                end
                S_BIT: begin
                    if (i_st.code_phase) r_state <= S_CMP;
                    else if (i_st.val_done) r_state <= S_FIN;
                    else r_state <= S_NEXT;
                end
                S_CMP: if (i_st.can_emit) r_state <= i_st.match ? S_SYM : S_NEXT;
                S_SYM: r_state <= i_st.sym_zero ? S_FIN : S_NEXT;
                S_FIN: if (i_st.can_emit) r_state <= i_st.fin_eob ? S_EOB : S_NEXT;
                S_EOB: if (i_st.can_emit) r_state <= S_NEXT;
                S_NEXT: r_state <= i_st.bits_done ? S_FLUSH : S_BIT;
                S_FLUSH: if (i_st.flush_ok) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/jhmd_dpath.sv
// tables, bit accumulators, block cursor and result registers
`default_nettype none
module jhmd_dpath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  jhmd_pkg::t_cmd    i_cmd,
    output jhmd_pkg::t_status o_st,
    input  wire  [1:0]        i_action,
    input  wire  [31:0]       i_data,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [23:0]       i_cfg_data,
    input  wire               i_m_tready,
    output logic              o_m_tvalid,
    output jhmd_pkg::t_result o_res,
    output logic              o_last
);

    // configuration
    logic [2:0]  r_ccount;
    logic [23:0] r_sampling;
    logic [15:0] r_tsel;

    // latched word
    logic [1:0] r_action;
    logic [7:0] r_byte;
    logic       r_cls;
    logic [1:0] r_tid;
    logic [4:0] r_len;
    logic [7:0] r_sidx;
    logic [7:0] r_entry;

    // decode state
    logic [15:0] r_pred [jhmd_pkg::MAX_COMPONENTS];
    logic [15:0] r_code;
    logic [4:0]  r_bits;
    logic [24:0] r_start;
    logic [7:0]  r_idx;
    logic [14:0] r_val;
    logic [3:0]  r_vsize;
    logic [3:0]  r_vleft;
    logic [3:0]  r_zr;
    logic [5:0]  r_pos;
    logic [1:0]  r_phase;
    logic [7:0]  r_cursor;
    logic        r_saw_ff;
    logic [7:0]  r_shift;
    logic [3:0]  r_nbits;

    // tables
    logic [7:0] r_counts [2 * jhmd_pkg::TABLES_PER_CLASS * jhmd_pkg::MAX_CODE_LENGTH];
    logic [7:0] r_syms [2 * jhmd_pkg::TABLES_PER_CLASS * jhmd_pkg::SYMBOLS_PER_TABLE];
    logic [7:0] r_cnt_q;
    logic [7:0] r_sym_q;

    // results
    logic                r_pend_valid;
    jhmd_pkg::t_result   r_pend;
    logic                r_out_valid;
    jhmd_pkg::t_result   r_out;
    logic                r_out_last;

    logic [1:0]  comp;
    logic [5:0]  blk;
    logic        cls;
    logic [1:0]  tid;
    logic [24:0] code_ext;
    logic [24:0] diff;
    logic        match;
    logic        full;
    logic        bit_in;
    logic [7:0]  sym_idx;
    logic [15:0] val16;
    logic        vmsb;
    logic [15:0] pred_sum;
    logic [6:0]  pos_run;
    logic [6:0]  pos_skip;
    logic        fin_dc;
    logic        fin_coef;
    logic        fin_eob;
    logic [2:0]  h_f;
    logic [2:0]  v_f;
    logic [5:0]  hv;
    logic [6:0]  blk_inc;
    logic [2:0]  comp_inc;
    logic [2:0]  active;
    logic        wrap;
    logic        mcu_end;
    logic [7:0]  next_cursor;
    logic        out_free;
    logic        e_valid;
    jhmd_pkg::t_result e_res;

    assign comp     = r_cursor[7:6];
    assign blk      = r_cursor[5:0];
    assign cls      = r_phase[1];
    assign tid      = r_tsel[{comp, cls, 1'b0} +: 2];
    assign code_ext = {9'd0, r_code};
    assign diff     = code_ext - r_start;
    assign match    = (code_ext >= r_start) && (diff < {17'd0, r_cnt_q});
    assign full     = (r_bits == 5'(jhmd_pkg::MAX_CODE_LENGTH));
    assign bit_in   = r_shift[7];
    assign sym_idx  = r_idx + diff[7:0];

    // sign extension of the value bits
    assign vmsb  = r_val[r_vsize - 4'd1];
    always_comb begin
        if (r_vsize == 4'd0) val16 = 16'd0;
        else if (vmsb) val16 = {1'b0, r_val};
        else val16 = {1'b0, r_val} - (16'd1 << r_vsize) + 16'd1;
    end
    assign pred_sum = r_pred[comp] + val16;
    assign pos_run  = {1'b0, r_pos} + {3'd0, r_zr};
    assign pos_skip = pos_run + 7'd1;
    assign fin_dc   = (r_phase == jhmd_pkg::PH_DC_BITS);
    assign fin_coef = fin_dc || (r_vsize != 4'd0 && pos_run <= jhmd_pkg::LAST_POSITION);
    assign fin_eob  = !fin_dc && ((r_vsize == 4'd0 && r_zr == 4'd0)
                                  || pos_skip > jhmd_pkg::LAST_POSITION);

    // block cursor advance
    assign h_f      = (r_sampling[{comp, 2'b00} + {comp, 1'b0} +: 3] == 3'd0) ? 3'd1
                    : r_sampling[{comp, 2'b00} + {comp, 1'b0} +: 3];
    assign v_f      = (r_sampling[{comp, 2'b00} + {comp, 1'b0} + 5'd3 +: 3] == 3'd0) ? 3'd1
                    : r_sampling[{comp, 2'b00} + {comp, 1'b0} + 5'd3 +: 3];
    assign hv       = h_f * v_f;
    assign blk_inc  = {1'b0, blk} + 7'd1;
    assign comp_inc = {1'b0, comp} + 3'd1;
    assign active   = (r_ccount == 3'd0) ? 3'd1
                    : (r_ccount > 3'(jhmd_pkg::MAX_COMPONENTS)) ? 3'(jhmd_pkg::MAX_COMPONENTS)
                    : r_ccount;
    assign wrap     = blk_inc >= {1'b0, hv};
    assign mcu_end  = wrap && (comp_inc >= active);
    always_comb begin
        if (!wrap) next_cursor = {comp, blk_inc[5:0]};
        else if (mcu_end) next_cursor = 8'd0;
        else next_cursor = {comp_inc[1:0], 6'd0};
    end

    // result selection
    always_comb begin
        e_valid = 1'b1;
        e_res   = '0;
        priority if (i_cmd.restart) begin
            e_res.kind = jhmd_pkg::KIND_RESTART;
        end else if (i_cmd.stop) begin
            e_res.kind = jhmd_pkg::KIND_STOP;
            e_res.comp = comp;
            e_res.blk  = blk[3:0];
        end else if (i_cmd.cmp_step && !match && full) begin
            e_res.kind = jhmd_pkg::KIND_INVALID;
            e_res.comp = comp;
            e_res.blk  = blk[3:0];
        end else if (i_cmd.fin_step && fin_coef) begin
            e_res.kind = jhmd_pkg::KIND_COEF;
            e_res.comp = comp;
            e_res.blk  = blk[3:0];
            e_res.pos  = fin_dc ? 6'd0 : pos_run[5:0];
            e_res.coef = fin_dc ? pred_sum : val16;
        end else if (i_cmd.eob_step) begin
            e_res.kind = jhmd_pkg::KIND_EOB;
            e_res.comp = comp;
            e_res.blk  = blk[3:0];
            e_res.done = mcu_end;
        end else begin
            e_valid = 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_st            = '0;
        o_st.action     = r_action;
        o_st.saw_ff     = r_saw_ff;
        o_st.byte_ff    = (r_byte == jhmd_pkg::BYTE_FF);
        o_st.byte_rst   = ((r_byte & jhmd_pkg::RST_MASK) == jhmd_pkg::RST_CODE);
        o_st.byte_zero  = (r_byte == 8'd0);
        o_st.code_phase = !r_phase[0];
        o_st.val_done   = (r_vleft == 4'd1);
        o_st.match      = match;
        o_st.sym_zero   = (r_sym_q[3:0] == 4'd0);
        o_st.fin_eob    = fin_eob;
        o_st.bits_done  = (r_nbits == 4'd0);
        o_st.can_emit   = !r_pend_valid || out_free;
        o_st.flush_ok   = !r_pend_valid || out_free;
        o_st.pend_valid = r_pend_valid;
    end

    // latched word and bit shifter
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_action;
            r_byte   <= i_data[7:0];
            r_cls    <= i_data[8];
            r_tid    <= i_data[10:9];
            r_len    <= i_data[15:11];
            r_sidx   <= i_data[23:16];
            r_entry  <= i_data[31:24];
        end
        if (i_cmd.load_bits) begin
            r_shift <= i_cmd.stuffed ? jhmd_pkg::BYTE_FF : r_byte;
        end else if (i_cmd.bit_step) begin
            r_shift <= {r_shift[6:0], 1'b0};
        end
    end

    // code count table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_count && r_len >= 5'd1
            && r_len <= 5'(jhmd_pkg::MAX_CODE_LENGTH)) begin
            r_counts[{r_cls, r_tid, 4'(r_len - 5'd1)}] <= r_entry;
        end
        if (i_cmd.bit_step) r_cnt_q <= r_counts[{cls, tid, r_bits[3:0]}];
    end

    // symbol table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sym) r_syms[{r_cls, r_tid, r_sidx}] <= r_entry;
        if (i_cmd.cmp_step) r_sym_q <= r_syms[{cls, tid, sym_idx}];
    end

    // configuration and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccount   <= 3'd1;
            r_sampling <= 24'd2396745;
            r_tsel     <= 16'd0;
            for (int i = 0; i < jhmd_pkg::MAX_COMPONENTS; i++) r_pred[i] <= 16'd0;
            r_code   <= 16'd0;
            r_bits   <= 5'd0;
            r_start  <= 25'd0;
            r_idx    <= 8'd0;
            r_val    <= 15'd0;
            r_vsize  <= 4'd0;
            r_vleft  <= 4'd0;
            r_zr     <= 4'd0;
            r_pos    <= 6'd0;
            r_phase  <= jhmd_pkg::PH_DC_CODE;
            r_cursor <= 8'd0;
            r_saw_ff <= 1'b0;
            r_nbits  <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    jhmd_pkg::CFG_COMPONENT_COUNT: r_ccount   <= i_cfg_data[2:0];
                    jhmd_pkg::CFG_SAMPLING:        r_sampling <= i_cfg_data;
                    jhmd_pkg::CFG_TABLE_SELECT:    r_tsel     <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.set_ff) r_saw_ff <= 1'b1;
            if (i_cmd.clr_ff) r_saw_ff <= 1'b0;
            if (i_cmd.load_bits) r_nbits <= 4'd8;
            if (i_cmd.restart) begin
                for (int i = 0; i < jhmd_pkg::MAX_COMPONENTS; i++) r_pred[i] <= 16'd0;
                r_code   <= 16'd0;
                r_bits   <= 5'd0;
                r_start  <= 25'd0;
                r_idx    <= 8'd0;
                r_val    <= 15'd0;
                r_vleft  <= 4'd0;
                r_zr     <= 4'd0;
                r_pos    <= 6'd0;
                r_phase  <= jhmd_pkg::PH_DC_CODE;
                r_cursor <= 8'd0;
            end
            if (i_cmd.bit_step) begin
                r_nbits <= r_nbits - 4'd1;
                if (!r_phase[0]) begin
                    r_code <= {r_code[14:0], bit_in};
                    r_bits <= r_bits + 5'd1;
                end else begin
                    r_val   <= {r_val[13:0], bit_in};
                    r_vleft <= r_vleft - 4'd1;
                end
            end
            if (i_cmd.cmp_step && !match) begin
                if (full) begin
                    r_code  <= 16'd0;
                    r_bits  <= 5'd0;
                    r_start <= 25'd0;
                    r_idx   <= 8'd0;
                end else begin
                    r_start <= (r_start + {17'd0, r_cnt_q}) << 1;
                    r_idx   <= r_idx + r_cnt_q;
                end
            end
            if (i_cmd.sym_step) begin
                r_zr    <= cls ? r_sym_q[7:4] : 4'd0;
                r_vsize <= r_sym_q[3:0];
                r_vleft <= r_sym_q[3:0];
                r_val   <= 15'd0;
                r_code  <= 16'd0;
                r_bits  <= 5'd0;
                r_start <= 25'd0;
                r_idx   <= 8'd0;
                r_phase <= r_phase + 2'd1;
            end
            if (i_cmd.fin_step) begin
                r_val   <= 15'd0;
                r_vleft <= 4'd0;
                if (fin_dc) begin
                    r_pred[comp] <= pred_sum;
                    r_phase      <= jhmd_pkg::PH_AC_CODE;
                    r_pos        <= 6'd1;
                end else if (!fin_eob) begin
                    r_pos   <= pos_skip[5:0];
                    r_phase <= jhmd_pkg::PH_AC_CODE;
                end
            end
            if (i_cmd.eob_step) begin
                r_cursor <= next_cursor;
                r_phase  <= jhmd_pkg::PH_DC_CODE;
                r_pos    <= 6'd0;
            end
        end
    end

    // one held result and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (e_valid) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) r_out_valid <= 1'b1;
                else if (i_m_tready) r_out_valid <= 1'b0;
            end else if (i_cmd.flush && r_pend_valid) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            r_pend <= e_res;
            if (r_pend_valid) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (i_cmd.flush && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire

### rtl/jpeg_huffman_mcu_decoder.sv
// top level of the baseline huffman mcu decoder
`default_nettype none
// Huffman entropy decoder for baseline scans. Words with tuser = 1 or 2 load the
// canonical tables (code count per length, symbol list); words with tuser = 0 carry
// scan bytes, decoded one bit per step, msb first. Results are dc and nonzero ac
// coefficients in zigzag order, end-of-block, restart, stop and invalid-code records;
// the final result of a word carries tlast. FF00 is taken as a stuffed FF, FFD0..FFD7
// clears the dc predictors and the block cursor, FFFF is fill, any other marker stops.
// A load word is written to its table. A scan byte is decoded bit by bit: a value bit is
// shifted in directly, and a code bit is followed by the registered read of the code
// count table and, on a match, of the symbol table; finishing a value and each result
// add a step of their own. A new word is taken once every result of the previous one
// sits in the output register. Configuration is to be written only while the block is
// idle; the block itself does not enforce it.
module jpeg_huffman_mcu_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input word
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,  // data_byte, table_class, table_id, code_length,
                                    // symbol_index, entry_value
    input  wire  [1:0]  i_s_tuser,  // action
    // result word
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,  // component, block_index, scan_position,
                                    // coefficient, mcu_done, zero fill
    output logic [2:0]  o_m_tuser,  // kind
    output logic        o_m_tlast,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);

    jhmd_pkg::t_cmd    cmd;
    jhmd_pkg::t_status st;
    jhmd_pkg::t_result res;
    logic              take;

    assign o_cfg_ready = 1'b1;
    assign take        = i_s_tvalid && o_s_tready;

    // sequencer: one state per step of the bit loop
    jhmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_st    (st),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    // tables, accumulators, cursor and output register
    jhmd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_action    (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_res       (res),
        .o_last      (o_m_tlast)
    );

    assign o_m_tuser = res.kind;
    assign o_m_tdata = {3'd0, res.done, res.coef, res.pos, res.blk, res.comp};

    // a new word is only taken once every held result has gone to the output register
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !st.pend_valid)
        else $error("word accepted with a result still held");

    // steps that may produce a result only run when there is room for it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cmp_step || cmd.fin_step || cmd.eob_step || cmd.restart || cmd.stop)
            |-> st.can_emit)
        else $error("result produced with no room");

    // an accepted word is always dispatched before the next one
    a_take_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !o_s_tready)
        else $error("word not dispatched");

endmodule
`default_nettype wire
